### rtl/longest_wait_slot_scheduler_assert.svh
// Assertion macros for the scheduler RTL
`ifndef LONGEST_WAIT_SLOT_SCHEDULER_ASSERT_SVH
`define LONGEST_WAIT_SLOT_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define LWSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LWSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lwss_pkg.sv
// Shared codes, field widths and FSM type for the slot scheduler
`timescale 1ns / 1ps

package lwss_pkg;

    localparam int SLOT_W  = 6;
    localparam int KIND_W  = 2;
    localparam int STATE_W = 2;
    localparam int AMT_W   = 16;

    localparam logic [AMT_W-1:0] TICK_RESET = 16'd10;

    // operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // slot state codes
    localparam logic [STATE_W-1:0] ST_EMPTY = 2'd0;
    localparam logic [STATE_W-1:0] ST_READY = 2'd1;
    localparam logic [STATE_W-1:0] ST_SUSP  = 2'd2;
    localparam logic [STATE_W-1:0] ST_RUN   = 2'd3;

    // running-thread kind codes
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_IDLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SLOT = 2'd2;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DECIDE = 6'b001000,
        S_SWAP   = 6'b010000,
        S_DONE   = 6'b100000
    } t_fsm;

endpackage

### rtl/lwss_if.sv
// Handshake channel interfaces: input items, results, tick configuration
`timescale 1ns / 1ps

interface lwss_in_if;
    import lwss_pkg::*;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [SLOT_W-1:0]  slot;
    logic [STATE_W-1:0] new_state;

    modport source (output valid, operation, slot, new_state, input ready);
    modport sink   (input valid, operation, slot, new_state, output ready);
endinterface

interface lwss_out_if;
    import lwss_pkg::*;
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] current_slot;
    logic [KIND_W-1:0] current_kind;
    logic              switched;
    logic [SLOT_W-1:0] previous_slot;
    logic [KIND_W-1:0] previous_kind;

    modport source (output valid, current_slot, current_kind, switched, previous_slot,
                    previous_kind, input ready);
    modport sink   (input valid, current_slot, current_kind, switched, previous_slot,
                    previous_kind, output ready);
endinterface

interface lwss_cfg_if;
    import lwss_pkg::*;
    logic             valid;
    logic             ready;
    logic [AMT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### rtl/lwss_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle
`timescale 1ns / 1ps

module lwss_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/longest_wait_slot_scheduler.sv
// Set_state: the beat is accepted in S_IDLE, then S_DONE registers the result once the output is free.
// Tick: one pass over the slot RAM, one entry read and written back per cycle;
//   then S_DECIDE, S_SWAP on a switch (old runner written ready, new slot written running), S_DONE.
// One item in flight; the next beat is taken once the result sits in the output register.
// Reset (sync, active low): a clearing pass writes every slot empty with zero time,
//   no input beat taken meanwhile; tick_amount returns to 10.
`timescale 1ns / 1ps

`include "longest_wait_slot_scheduler_assert.svh"

module longest_wait_slot_scheduler #(
    parameter int SLOTS     = 64,
    parameter int TIME_BITS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lwss_in_if.sink    i_in,
    lwss_cfg_if.sink   i_cfg,
    lwss_out_if.source o_out
);

    import lwss_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int XW = (IW > SLOT_W) ? IW : SLOT_W;
    localparam int SW = ((TIME_BITS > AMT_W) ? TIME_BITS : AMT_W) + 1;
    localparam int EW = STATE_W + TIME_BITS;
    localparam logic [IW-1:0]        LAST     = IW'(SLOTS - 1);
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // control state
    t_fsm              r_state, n_state;
    logic [IW-1:0]     r_clr_addr, n_clr_addr;
    logic [AMT_W-1:0]  r_tick, n_tick;
    logic [KIND_W-1:0] r_run_kind, n_run_kind;
    logic [IW-1:0]     r_run_idx, n_run_idx;
    logic              r_run_drop, n_run_drop;
    logic              r_out_valid, n_out_valid;

    // per-item working registers
    logic              r_op, n_op;
    logic [KIND_W-1:0] r_prev_kind, n_prev_kind;
    logic [IW-1:0]     r_prev_idx, n_prev_idx;
    logic [IW-1:0]     r_wb_addr, n_wb_addr;
    logic              r_found, n_found;
    logic [IW-1:0]     r_best_idx, n_best_idx;
    logic [TIME_BITS-1:0] r_best_time, n_best_time;
    logic [TIME_BITS-1:0] r_run_time, n_run_time;

    // result register
    logic [SLOT_W-1:0] r_out_cur_slot, n_out_cur_slot;
    logic [KIND_W-1:0] r_out_cur_kind, n_out_cur_kind;
    logic              r_out_sw, n_out_sw;
    logic [SLOT_W-1:0] r_out_prev_slot, n_out_prev_slot;
    logic [KIND_W-1:0] r_out_prev_kind, n_out_prev_kind;

    // RAM ports
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [IW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;

    lwss_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    logic                 in_fire;
    logic                 out_free;
    logic [STATE_W-1:0]   rd_state;
    logic [TIME_BITS-1:0] rd_time;
    logic [SW-1:0]        sum;
    logic [TIME_BITS-1:0] new_time;
    logic                 better;
    logic                 keep;
    logic                 slot_ok;
    logic [IW-1:0]        set_idx;
    logic                 is_running;
    logic [XW-1:0]        cur_ext;
    logic [XW-1:0]        prev_ext;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;

    // per-entry update during the scan
    assign rd_state = mem_rdata[EW-1:TIME_BITS];
    assign rd_time  = mem_rdata[TIME_BITS-1:0];
    assign sum      = SW'(rd_time) + SW'(r_tick);
    always_comb begin
        if (rd_state == ST_READY || rd_state == ST_RUN) begin
            new_time = (sum > SW'(TIME_MAX)) ? TIME_MAX : sum[TIME_BITS-1:0];
        end else begin
            new_time = rd_time;
        end
    end
    // strict compare in ascending order keeps the lowest index on ties
    assign better = (rd_state == ST_READY) && (!r_found || new_time > r_best_time);
    assign keep   = (r_run_kind == KIND_SLOT) && (SW'(r_run_time) <= SW'(r_tick));

    assign slot_ok    = 32'(i_in.slot) < 32'(SLOTS);
    assign set_idx    = IW'(i_in.slot);
    assign is_running = (r_run_kind == KIND_SLOT) && slot_ok && (set_idx == r_run_idx);

    assign cur_ext  = XW'(r_run_idx);
    assign prev_ext = XW'(r_prev_idx);

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_tick      = r_tick;
        n_run_kind  = r_run_kind;
        n_run_idx   = r_run_idx;
        n_run_drop  = r_run_drop;
        n_out_valid = r_out_valid && !o_out.ready;
        n_op        = r_op;
        n_prev_kind = r_prev_kind;
        n_prev_idx  = r_prev_idx;
        n_wb_addr   = r_wb_addr;
        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best_time = r_best_time;
        n_run_time  = r_run_time;
        n_out_cur_slot  = r_out_cur_slot;
        n_out_cur_kind  = r_out_cur_kind;
        n_out_sw        = r_out_sw;
        n_out_prev_slot = r_out_prev_slot;
        n_out_prev_kind = r_out_prev_kind;
        mem_we    = 1'b0;
        mem_waddr = r_wb_addr;
        mem_wdata = {ST_EMPTY, {TIME_BITS{1'b0}}};
        mem_raddr = (r_wb_addr == LAST) ? '0 : r_wb_addr + 1'b1;

        if (i_cfg.valid && i_cfg.ready) begin
            n_tick = i_cfg.data;
        end

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                if (r_clr_addr == LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_op        = i_in.operation;
                    n_prev_kind = r_run_kind;
                    n_prev_idx  = r_run_idx;
                    if (i_in.operation == OP_SET) begin
                        n_state = S_DONE;
                        if (slot_ok && i_in.new_state != ST_RUN &&
                            !(is_running && i_in.new_state == ST_READY)) begin
                            mem_we    = 1'b1;
                            mem_waddr = set_idx;
                            mem_wdata = {i_in.new_state, {TIME_BITS{1'b0}}};
                            if (is_running) begin
                                n_run_drop = 1'b1;
                            end
                        end
                    end else begin
                        n_state     = S_SCAN;
                        mem_raddr   = '0;
                        n_wb_addr   = '0;
                        n_found     = 1'b0;
                        n_best_idx  = '0;
                        n_best_time = '0;
                        n_run_time  = '0;
                        // running slot marked empty or suspended leaves now
                        if (r_run_kind == KIND_SLOT && r_run_drop) begin
                            n_run_kind = KIND_NONE;
                            n_run_idx  = '0;
                            n_run_drop = 1'b0;
                        end
                    end
                end
            end
            S_SCAN: begin
                mem_we    = 1'b1;
                mem_waddr = r_wb_addr;
                mem_wdata = {rd_state, new_time};
                if (better) begin
                    n_found     = 1'b1;
                    n_best_idx  = r_wb_addr;
                    n_best_time = new_time;
                end
                if (r_run_kind == KIND_SLOT && r_wb_addr == r_run_idx) begin
                    n_run_time = new_time;
                end
                if (r_wb_addr == LAST) begin
                    n_state = S_DECIDE;
                end else begin
                    n_wb_addr = r_wb_addr + 1'b1;
                end
            end
            S_DECIDE: begin
                if (keep) begin
                    n_state = S_DONE;
                end else if (r_found) begin
                    n_state = S_SWAP;
                    if (r_run_kind == KIND_SLOT) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_run_idx;
                        mem_wdata = {ST_READY, {TIME_BITS{1'b0}}};
                    end
                end else begin
                    n_state = S_DONE;
                    if (r_run_kind == KIND_NONE) begin
                        n_run_kind = KIND_IDLE;
                    end
                end
            end
            S_SWAP: begin
                mem_we     = 1'b1;
                mem_waddr  = r_best_idx;
                mem_wdata  = {ST_RUN, {TIME_BITS{1'b0}}};
                n_run_kind = KIND_SLOT;
                n_run_idx  = r_best_idx;
                n_run_drop = 1'b0;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out_cur_slot  = cur_ext[SLOT_W-1:0];
                    n_out_cur_kind  = r_run_kind;
                    n_out_sw        = (r_run_kind != r_prev_kind) || (r_run_idx != r_prev_idx);
                    n_out_prev_slot = prev_ext[SLOT_W-1:0];
                    n_out_prev_kind = r_prev_kind;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_tick      <= TICK_RESET;
            r_run_kind  <= KIND_NONE;
            r_run_idx   <= '0;
            r_run_drop  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_tick      <= n_tick;
            r_run_kind  <= n_run_kind;
            r_run_idx   <= n_run_idx;
            r_run_drop  <= n_run_drop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op            <= n_op;
        r_prev_kind     <= n_prev_kind;
        r_prev_idx      <= n_prev_idx;
        r_wb_addr       <= n_wb_addr;
        r_found         <= n_found;
        r_best_idx      <= n_best_idx;
        r_best_time     <= n_best_time;
        r_run_time      <= n_run_time;
        r_out_cur_slot  <= n_out_cur_slot;
        r_out_cur_kind  <= n_out_cur_kind;
        r_out_sw        <= n_out_sw;
        r_out_prev_slot <= n_out_prev_slot;
        r_out_prev_kind <= n_out_prev_kind;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.current_slot  = r_out_cur_slot;
    assign o_out.current_kind  = r_out_cur_kind;
    assign o_out.switched      = r_out_sw;
    assign o_out.previous_slot = r_out_prev_slot;
    assign o_out.previous_kind = r_out_prev_kind;

    `LWSS_ASSERT_IMP(a_idx_only_for_slot, i_clk, i_rst_n, r_run_kind != KIND_SLOT, r_run_idx == '0, "running index set while no table slot runs")
    `LWSS_ASSERT_IMP(a_drop_needs_slot, i_clk, i_rst_n, r_run_drop, r_run_kind == KIND_SLOT, "drop pending with no running slot")
    `LWSS_ASSERT_IMP(a_tick_leaves_runner, i_clk, i_rst_n, r_state == S_DONE && r_op == OP_TICK, r_run_kind != KIND_NONE, "tick finished with nothing running")
    `LWSS_ASSERT_IMP(a_switch_differs, i_clk, i_rst_n, r_out_valid && r_out_sw, r_out_cur_kind != r_out_prev_kind || r_out_cur_slot != r_out_prev_slot, "switch flagged with same thread")
    `LWSS_ASSERT_NXT(a_swap_installs, i_clk, i_rst_n, r_state == S_SWAP, r_run_kind == KIND_SLOT && !r_run_drop && r_state == S_DONE, "swap did not install new slot")

endmodule

### verif/tb_top.sv
// Testbench for the slot scheduler: random and directed items checked against a local model
`timescale 1ns / 1ps

module tb_top;
    import lwss_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0] cur_slot;
        logic [KIND_W-1:0] cur_kind;
        logic              switched;
        logic [SLOT_W-1:0] prev_slot;
        logic [KIND_W-1:0] prev_kind;
    } t_decision;

    // Tracks the slot table and holds the decisions still owed by the block
    class t_decision_board;
        bit [STATE_W-1:0] slot_st [64];
        bit [31:0]        wait_t  [64];
        bit [KIND_W-1:0]  run_kind;
        bit [SLOT_W-1:0]  run_slot;
        bit [AMT_W-1:0]   slice;
        t_decision        pending_decisions [$];
        int               errors;

        function new();
            for (int i = 0; i < 64; i++) begin
                slot_st[i] = ST_EMPTY;
                wait_t[i]  = '0;
            end
            run_kind = KIND_NONE;
            run_slot = '0;
            slice    = TICK_RESET;
            errors   = 0;
        endfunction

        function void set_slice(bit [AMT_W-1:0] v);
            slice = v;
        endfunction

        function int pending();
            return pending_decisions.size();
        endfunction

        function void note_item(logic op, logic [SLOT_W-1:0] s, logic [STATE_W-1:0] ns);
            t_decision d;
            bit [32:0] sum;
            bit        found;
            bit [SLOT_W-1:0] best;
            bit [31:0] best_t;
            d.prev_kind = run_kind;
            d.prev_slot = (run_kind == KIND_SLOT) ? run_slot : '0;
            if (op == OP_SET) begin
                // running slot ignores a ready write; code 3 is never stored
                if (ns != ST_RUN && !(run_kind == KIND_SLOT && run_slot == s && ns == ST_READY))
                begin
                    slot_st[s] = ns;
                    wait_t[s]  = '0;
                end
            end else begin
                if (run_kind == KIND_SLOT && slot_st[run_slot] != ST_RUN) begin
                    run_kind = KIND_NONE;
                    run_slot = '0;
                end
                for (int i = 0; i < 64; i++) begin
                    if (slot_st[i] == ST_READY || slot_st[i] == ST_RUN) begin
                        sum       = {1'b0, wait_t[i]} + slice;
                        wait_t[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    end
                end
                if (!(run_kind == KIND_SLOT && wait_t[run_slot] <= slice)) begin
                    found  = 1'b0;
                    best   = '0;
                    best_t = '0;
                    for (int i = 0; i < 64; i++) begin
                        if (slot_st[i] == ST_READY && (!found || wait_t[i] > best_t)) begin
                            found  = 1'b1;
                            best   = SLOT_W'(i);
                            best_t = wait_t[i];
                        end
                    end
                    if (!found) begin
                        if (run_kind == KIND_NONE) begin
                            run_kind = KIND_IDLE;
                            run_slot = '0;
                        end
                    end else begin
                        if (run_kind == KIND_SLOT) begin
                            slot_st[run_slot] = ST_READY;
                            wait_t[run_slot]  = '0;
                        end
                        slot_st[best] = ST_RUN;
                        wait_t[best]  = '0;
                        run_kind      = KIND_SLOT;
                        run_slot      = best;
                    end
                end
            end
            d.cur_kind = run_kind;
            d.cur_slot = (run_kind == KIND_SLOT) ? run_slot : '0;
            d.switched = (d.cur_kind != d.prev_kind) || (d.cur_slot != d.prev_slot);
            pending_decisions.push_back(d);
        endfunction

        function void check_decision(t_decision got);
            t_decision want;
            if (pending_decisions.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result beat cur=%0d/%0d sw=%0d prev=%0d/%0d",
                             got.cur_kind, got.cur_slot, got.switched,
                             got.prev_kind, got.prev_slot);
                return;
            end
            want = pending_decisions.pop_front();
            if (got.cur_slot !== want.cur_slot || got.cur_kind !== want.cur_kind ||
                got.switched !== want.switched || got.prev_slot !== want.prev_slot ||
                got.prev_kind !== want.prev_kind) begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: mismatch exp cur=%0d/%0d sw=%0d prev=%0d/%0d,",
                              " got cur=%0d/%0d sw=%0d prev=%0d/%0d"},
                             want.cur_kind, want.cur_slot, want.switched,
                             want.prev_kind, want.prev_slot,
                             got.cur_kind, got.cur_slot, got.switched,
                             got.prev_kind, got.prev_slot);
            end
        endfunction

        function void flush_leftover();
            if (pending_decisions.size() != 0) begin
                errors += pending_decisions.size();
                if (errors <= 10)
                    $display("ERROR: %0d results never arrived", pending_decisions.size());
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lwss_in_if  in_if ();
    lwss_out_if out_if ();
    lwss_cfg_if cfg_if ();

    t_decision_board board = new();

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_req     = 1'b0;
    bit rx_hold      = 1'b0;

    longest_wait_slot_scheduler u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("longest_wait_slot_scheduler test failed");
        $finish;
    end

    // long receiver hold-off, counted here so the sender keeps pushing meanwhile
    initial begin
        wait (hold_req);
        rx_hold = 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin : result_sink
        t_decision got;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
            @(posedge i_clk);
            if (i_rst_n && out_if.valid === 1'b1 && out_if.ready) begin
                got.cur_slot  = out_if.current_slot;
                got.cur_kind  = out_if.current_kind;
                got.switched  = out_if.switched;
                got.prev_slot = out_if.previous_slot;
                got.prev_kind = out_if.previous_kind;
                board.check_decision(got);
            end
        end
    end

    task automatic send_item(input logic op, input logic [SLOT_W-1:0] s,
                             input logic [STATE_W-1:0] ns);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.operation <= op;
        in_if.slot      <= s;
        in_if.new_state <= ns;
        do @(posedge i_clk); while (!in_if.ready);
        board.note_item(op, s, ns);
    endtask

    // drop valid and let every owed result come back
    task automatic wait_for_decisions();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_slice(input logic [AMT_W-1:0] v);
        wait_for_decisions();
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        board.set_slice(v);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // mostly a few hot slots so several threads compete; some hits on the running slot
    task automatic random_items(input int n, input bit hold, input bit pause);
        logic               op;
        logic [SLOT_W-1:0]  s;
        logic [STATE_W-1:0] ns;
        int                 r;
        for (int k = 0; k < n; k++) begin
            if (k == n / 2) begin
                if (hold)
                    hold_req = 1'b1;
                if (pause)
                    wait_for_decisions();
            end
            op = ($urandom_range(99) < 35) ? OP_TICK : OP_SET;
            r  = $urandom_range(99);
            if (r < 10 && board.run_kind == KIND_SLOT)
                s = board.run_slot;
            else if (r < 75)
                s = SLOT_W'($urandom_range(7));
            else
                s = SLOT_W'($urandom_range(63));
            r = $urandom_range(99);
            if (r < 25)
                ns = ST_EMPTY;
            else if (r < 70)
                ns = ST_READY;
            else if (r < 92)
                ns = ST_SUSP;
            else
                ns = ST_RUN;
            send_item(op, s, ns);
        end
    endtask

    initial begin
        in_if.valid     = 1'b0;
        in_if.operation = OP_TICK;
        in_if.slot      = '0;
        in_if.new_state = ST_EMPTY;
        cfg_if.valid    = 1'b0;
        cfg_if.data     = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset slice
        send_item(OP_TICK, 6'd0,  ST_EMPTY);   // nothing running -> idle thread
        send_item(OP_SET,  6'd0,  ST_READY);
        send_item(OP_SET,  6'd63, ST_READY);
        send_item(OP_TICK, 6'd0,  ST_EMPTY);   // tie, lowest index wins
        send_item(OP_TICK, 6'd0,  ST_EMPTY);   // within slice, keeps
        send_item(OP_TICK, 6'd0,  ST_EMPTY);   // over slice, switch
        send_item(OP_SET,  6'd63, ST_READY);   // ready on running slot: ignored
        send_item(OP_SET,  6'd63, ST_RUN);     // code 3 ignored
        send_item(OP_SET,  6'd1,  ST_RUN);
        send_item(OP_SET,  6'd63, ST_SUSP);    // still shown running until tick
        send_item(OP_SET,  6'd63, ST_READY);
        send_item(OP_TICK, 6'd0,  ST_EMPTY);   // suspended runner dropped
        send_item(OP_SET,  6'd0,  ST_EMPTY);
        send_item(OP_TICK, 6'd0,  ST_EMPTY);   // dropped, nothing left -> idle
        send_item(OP_SET,  6'd2,  ST_SUSP);
        send_item(OP_SET,  6'd2,  ST_READY);
        send_item(OP_SET,  6'd42, ST_READY);
        send_item(OP_SET,  6'd21, ST_READY);
        send_item(OP_TICK, 6'd0,  ST_EMPTY);
        send_item(OP_SET,  6'd21, ST_EMPTY);
        send_item(OP_SET,  6'd42, ST_SUSP);
        send_item(OP_TICK, 6'd0,  ST_EMPTY);
        send_item(OP_TICK, 6'd0,  ST_EMPTY);   // over slice, no candidate: stays
        send_item(OP_TICK, 6'd0,  ST_EMPTY);

        write_slice(TICK_RESET);
        random_items(300, 1'b0, 1'b0);

        write_slice(16'd1);
        tx_idle_pct = 87;
        random_items(250, 1'b0, 1'b0);

        write_slice(16'hFFFF);
        tx_idle_pct  = 0;
        rx_stall_pct = 87;
        random_items(250, 1'b1, 1'b0);

        // zero slice: nothing accrues, a zero-time ready slot still gets picked
        write_slice(16'd0);
        tx_idle_pct  = 33;
        rx_stall_pct = 33;
        random_items(150, 1'b0, 1'b0);

        write_slice(AMT_W'($urandom_range(65535, 1)));
        random_items(300, 1'b0, 1'b1);

        write_slice(AMT_W'($urandom_range(40, 2)));
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        random_items(400, 1'b0, 1'b0);

        wait_for_decisions();
        repeat (100) @(posedge i_clk);
        board.flush_leftover();
        if (board.errors == 0)
            $display("longest_wait_slot_scheduler test passed");
        else
            $display("longest_wait_slot_scheduler test failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/lwss_pkg.sv
rtl/lwss_if.sv
rtl/lwss_ram.sv
rtl/longest_wait_slot_scheduler.sv
verif/tb_top.sv
